### hw/rtl/pmd_pkg.sv
// ----------------------------------------------------------------------------
// pmd_pkg
// Shared types and default constants for the motor drive and chop sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package pmd_pkg;

  // parameter defaults
  localparam int SPEED_LEVELS_DEF = 8;
  localparam int PWM_BITS_DEF     = 8;

  // chop sequencer phases, also the value of the phase output field
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_DOWN  = 3'd1,
    PH_SDOWN = 3'd2,
    PH_UP    = 3'd3,
    PH_SUP   = 3'd4
  } phase_t;

  // configuration seen by the sequencer
  typedef struct packed {
    logic [7:0] down_edges;
    logic [7:0] up_edges;
    logic [3:0] timeout_limit;
    logic [9:0] settle_ms;
    logic [7:0] axe_duty;
    logic [3:0] repeat_chops;
  } seq_cfg_t;

  // sequencer view after the current item
  typedef struct packed {
    phase_t     phase;
    logic       axe_dir;
    logic [7:0] axe_duty;
    logic       axe_drop;
  } seq_out_t;

endpackage

`default_nettype wire

### hw/rtl/pwm_motor_drive_and_chop_sequencer.sv
// ----------------------------------------------------------------------------
// pwm_motor_drive_and_chop_sequencer
// Two drive motor pwm channels plus an attack motor chop sequencer.
// ----------------------------------------------------------------------------
// Usage: every transfer on the s_ channel is one system tick carrying pwm,
// timeout and millisecond strobes, the attack encoder level, the drive levels
// and directions and an optional chop request. Each accepted item yields
// exactly one m_ transfer with the enable and direction pin levels, busy
// and the sequencer phase after that tick.
// The configuration port writes one register per cycle on cfg_we; write it
// only while no item is in flight.
// m_tvalid rises in the cycle after an s_ transfer; throughput is one item
// per cycle, set by the single result register that follows the state
// update. While m_tready is low with a result held, s_tready drops and the
// state holds; once the result goes out a new item is taken the same cycle.
// Reset clears the pwm counter, enables, sequencer (idle) and the output valid
// flag, and loads the register defaults (25, 35, 5, 100, 128, 5, 60, 90).
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_motor_drive_and_chop_sequencer #(
  parameter int SPEED_LEVELS = pmd_pkg::SPEED_LEVELS_DEF,
  parameter int PWM_BITS     = pmd_pkg::PWM_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // action[1:0], pwm_tick[2], timeout_tick[3], ms_tick[4], encoder_level[5],
  // left_level[9:6], right_level[13:10], left_reverse[14], right_reverse[15]
  input  wire logic [15:0] s_tdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // left_enable[0], right_enable[1], axe_enable[2], left_dir_pin[3],
  // right_dir_pin[4], axe_dir_pin[5], busy_res[6], phase[9:7], zero[15:10]
  output logic      [15:0] m_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [9:0]  cfg_wdata
);

  localparam logic [2:0] REG_DOWN_EDGES    = 3'd0;
  localparam logic [2:0] REG_UP_EDGES      = 3'd1;
  localparam logic [2:0] REG_TIMEOUT_LIMIT = 3'd2;
  localparam logic [2:0] REG_SETTLE_MS     = 3'd3;
  localparam logic [2:0] REG_AXE_DUTY      = 3'd4;
  localparam logic [2:0] REG_REPEAT_CHOPS  = 3'd5;
  localparam logic [2:0] REG_MIN_DUTY      = 3'd6;
  localparam logic [2:0] REG_DUTY_SPAN     = 3'd7;
  localparam int AW = (PWM_BITS > 8) ? PWM_BITS : 8;

  pmd_pkg::seq_cfg_t seq_cfg;
  pmd_pkg::seq_out_t seq_res;
  logic [7:0] min_duty;
  logic [7:0] duty_span;

  logic                step;
  logic [1:0]          action;
  logic                pwm_tick, timeout_tick, ms_tick, encoder_level;
  logic [3:0]          left_level, right_level;
  logic                left_reverse, right_reverse;

  logic [PWM_BITS-1:0] pwm_count, pwm_count_next;
  logic [2:0]          enable_bits, enable_bits_next;
  logic [1:0]          last_dirs;
  logic [PWM_BITS-1:0] left_duty, right_duty;
  logic [15:0]         result;

  assign action        = s_tdata[1:0];
  assign pwm_tick      = s_tdata[2];
  assign timeout_tick  = s_tdata[3];
  assign ms_tick       = s_tdata[4];
  assign encoder_level = s_tdata[5];
  assign left_level    = s_tdata[9:6];
  assign right_level   = s_tdata[13:10];
  assign left_reverse  = s_tdata[14];
  assign right_reverse = s_tdata[15];

  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_cfg.down_edges    <= 8'd25;
      seq_cfg.up_edges      <= 8'd35;
      seq_cfg.timeout_limit <= 4'd5;
      seq_cfg.settle_ms     <= 10'd100;
      seq_cfg.axe_duty      <= 8'd128;
      seq_cfg.repeat_chops  <= 4'd5;
      min_duty              <= 8'd60;
      duty_span             <= 8'd90;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DOWN_EDGES:    seq_cfg.down_edges    <= cfg_wdata[7:0];
        REG_UP_EDGES:      seq_cfg.up_edges      <= cfg_wdata[7:0];
        REG_TIMEOUT_LIMIT: seq_cfg.timeout_limit <= cfg_wdata[3:0];
        REG_SETTLE_MS:     seq_cfg.settle_ms     <= cfg_wdata;
        REG_AXE_DUTY:      seq_cfg.axe_duty      <= cfg_wdata[7:0];
        REG_REPEAT_CHOPS:  seq_cfg.repeat_chops  <= cfg_wdata[3:0];
        REG_MIN_DUTY:      min_duty              <= cfg_wdata[7:0];
        REG_DUTY_SPAN:     duty_span             <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  pmd_chop_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .action        (action),
    .timeout_tick  (timeout_tick),
    .ms_tick       (ms_tick),
    .encoder_level (encoder_level),
    .cfg           (seq_cfg),
    .res           (seq_res)
  );

  pmd_level_duty #(
    .SPEED_LEVELS (SPEED_LEVELS),
    .PWM_BITS     (PWM_BITS)
  ) u_left_duty (
    .level     (left_level),
    .min_duty  (min_duty),
    .duty_span (duty_span),
    .duty      (left_duty)
  );

  pmd_level_duty #(
    .SPEED_LEVELS (SPEED_LEVELS),
    .PWM_BITS     (PWM_BITS)
  ) u_right_duty (
    .level     (right_level),
    .min_duty  (min_duty),
    .duty_span (duty_span),
    .duty      (right_duty)
  );

  // sequencer drop, then direction drops, then the pwm tick overrides all
  always_comb begin
    enable_bits_next = enable_bits;
    pwm_count_next   = pwm_count;
    if (seq_res.axe_drop) begin
      enable_bits_next[2] = 1'b0;
    end
    if (left_reverse != last_dirs[0]) begin
      enable_bits_next[0] = 1'b0;
    end
    if (right_reverse != last_dirs[1]) begin
      enable_bits_next[1] = 1'b0;
    end
    if (pwm_tick) begin
      enable_bits_next[0] = pwm_count < left_duty;
      enable_bits_next[1] = pwm_count < right_duty;
      enable_bits_next[2] = AW'(pwm_count) < AW'(seq_res.axe_duty);
      pwm_count_next      = pwm_count + PWM_BITS'(1);
    end
  end

  assign result = {6'd0, seq_res.phase, (seq_res.phase != pmd_pkg::PH_IDLE),
                   seq_res.axe_dir, right_reverse, ~left_reverse, enable_bits_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_count   <= '0;
      enable_bits <= '0;
      last_dirs   <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (step) begin
        pwm_count   <= pwm_count_next;
        enable_bits <= enable_bits_next;
        last_dirs   <= {right_reverse, left_reverse};
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= result;
    end
  end

  // a held result blocks new input
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while a result is stalled");

  // counter moves only on a transferred pwm tick
  assert property (@(posedge clk) disable iff (rst)
    !(step && pwm_tick) |=> $stable(pwm_count))
    else $error("pwm counter moved without a pwm tick");

  // busy flag agrees with the phase field
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[6] == (m_tdata[9:7] != pmd_pkg::PH_IDLE)))
    else $error("busy and phase disagree");

endmodule

`default_nettype wire

### hw/rtl/pmd_level_duty.sv
// ----------------------------------------------------------------------------
// pmd_level_duty
// Maps a drive speed level (capped at levels) to a pwm duty: zero, or min + level*span/levels, clamped to the pwm max.
// ----------------------------------------------------------------------------
`default_nettype none

module pmd_level_duty #(
  parameter int SPEED_LEVELS = pmd_pkg::SPEED_LEVELS_DEF,
  parameter int PWM_BITS     = pmd_pkg::PWM_BITS_DEF
) (
  input  wire logic [3:0]          level,
  input  wire logic [7:0]          min_duty,
  input  wire logic [7:0]          duty_span,
  output logic      [PWM_BITS-1:0] duty
);

  // level*span stays below 2^12, so a rounded-up reciprocal with this
  // shift gives the exact quotient
  localparam int LV_W    = $clog2(SPEED_LEVELS + 1);
  localparam int SHIFT   = 12 + $clog2(SPEED_LEVELS);
  localparam int RECIP   = ((1 << SHIFT) + SPEED_LEVELS - 1) / SPEED_LEVELS;
  localparam int SCALE_W = SHIFT + 1;
  localparam int PROD_W  = SCALE_W + 8;
  localparam int DW      = (PWM_BITS > 9) ? PWM_BITS : 9;
  localparam logic [DW-1:0] PWM_MAX = DW'((1 << PWM_BITS) - 1);

  logic [SCALE_W-1:0] scale_tab [SPEED_LEVELS+1];
  logic [4:0]         lv_sat;
  logic [LV_W-1:0]    lv;
  logic [PROD_W-1:0]  prod;
  logic [7:0]         quot;
  logic [DW-1:0]      sum;

  // level * reciprocal, one constant per level
  for (genvar g = 0; g <= SPEED_LEVELS; g++) begin : g_scale
    assign scale_tab[g] = SCALE_W'(g * RECIP);
  end

  assign lv_sat = ({1'b0, level} > 5'(SPEED_LEVELS)) ? 5'(SPEED_LEVELS) : {1'b0, level};
  assign lv     = lv_sat[LV_W-1:0];
  assign prod   = PROD_W'(scale_tab[lv]) * PROD_W'(duty_span);
  assign quot   = prod[SHIFT+7:SHIFT];
  assign sum    = DW'(min_duty) + DW'(quot);

  always_comb begin
    if (lv_sat == 5'd0) begin
      duty = '0;
    end else if (sum > PWM_MAX) begin
      duty = PWM_MAX[PWM_BITS-1:0];
    end else begin
      duty = sum[PWM_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pmd_chop_seq.sv
// ----------------------------------------------------------------------------
// pmd_chop_seq
// Attack motor chop sequencer: down stroke, settle, up stroke, settle.
// ----------------------------------------------------------------------------
`default_nettype none

module pmd_chop_seq (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire logic [1:0]         action,
  input  wire logic               timeout_tick,
  input  wire logic               ms_tick,
  input  wire logic               encoder_level,
  input  wire pmd_pkg::seq_cfg_t  cfg,
  output pmd_pkg::seq_out_t       res
);

  localparam logic [1:0] ACT_ONE    = 2'd1;
  localparam logic [1:0] ACT_REPEAT = 2'd2;
  localparam logic [7:0] EDGE_MAX   = 8'hff;
  localparam logic [9:0] SETTLE_MAX = 10'h3ff;

  pmd_pkg::phase_t phase, phase_next;
  logic       axe_dir, axe_dir_next;
  logic [7:0] axe_duty_now, axe_duty_now_next;
  logic [7:0] edge_count, edge_count_next;
  logic       edge_ref, edge_ref_next;
  logic [3:0] overflow_count, overflow_count_next;
  logic [9:0] settle_count, settle_count_next;
  logic [3:0] chops_left, chops_left_next;
  logic       drop;

  always_comb begin
    logic [7:0] target;
    logic [7:0] ec;
    logic [9:0] sc;
    logic [3:0] cl;
    logic       start;
    pmd_pkg::phase_t start_ph;

    phase_next          = phase;
    axe_dir_next        = axe_dir;
    axe_duty_now_next   = axe_duty_now;
    edge_count_next     = edge_count;
    edge_ref_next       = edge_ref;
    overflow_count_next = overflow_count;
    settle_count_next   = settle_count;
    chops_left_next     = chops_left;
    start               = 1'b0;
    start_ph            = pmd_pkg::PH_DOWN;
    target              = (phase == pmd_pkg::PH_DOWN) ? cfg.down_edges : cfg.up_edges;
    ec                  = edge_count;
    sc                  = settle_count;
    cl                  = chops_left;

    case (phase)
      pmd_pkg::PH_DOWN, pmd_pkg::PH_UP: begin
        if (timeout_tick && (overflow_count >= cfg.timeout_limit)) begin
          overflow_count_next = '0;
          axe_duty_now_next   = '0;
          settle_count_next   = '0;
          phase_next = (phase == pmd_pkg::PH_DOWN) ? pmd_pkg::PH_SDOWN : pmd_pkg::PH_SUP;
        end else begin
          if (timeout_tick) begin
            overflow_count_next = overflow_count + 4'd1;
          end
          if (encoder_level != edge_ref) begin
            edge_ref_next = encoder_level;
            if (ec != EDGE_MAX) begin
              ec = ec + 8'd1;
            end
          end
          edge_count_next = ec;
          if (ec >= target) begin
            axe_duty_now_next = '0;
            settle_count_next = '0;
            phase_next = (phase == pmd_pkg::PH_DOWN) ? pmd_pkg::PH_SDOWN : pmd_pkg::PH_SUP;
          end
        end
      end
      pmd_pkg::PH_SDOWN, pmd_pkg::PH_SUP: begin
        if (ms_tick && (sc != SETTLE_MAX)) begin
          sc = sc + 10'd1;
        end
        settle_count_next = sc;
        if (sc >= cfg.settle_ms) begin
          if (phase == pmd_pkg::PH_SDOWN) begin
            start    = 1'b1;
            start_ph = pmd_pkg::PH_UP;
          end else begin
            cl = (cl != 4'd0) ? cl - 4'd1 : 4'd0;
            chops_left_next = cl;
            if (cl != 4'd0) begin
              start = 1'b1;
            end else begin
              phase_next = pmd_pkg::PH_IDLE;
            end
          end
        end
      end
      default: begin
        phase_next = pmd_pkg::PH_IDLE;
        if ((action == ACT_ONE) || (action == ACT_REPEAT)) begin
          cl = (action == ACT_ONE) ? 4'd1 : cfg.repeat_chops;
          chops_left_next = (cl == 4'd0) ? 4'd1 : cl;
          start = 1'b1;
        end
      end
    endcase

    // stroke start clears the stroke counters and loads the attack duty
    if (start) begin
      phase_next          = start_ph;
      axe_dir_next        = (start_ph == pmd_pkg::PH_DOWN);
      axe_duty_now_next   = cfg.axe_duty;
      edge_count_next     = '0;
      edge_ref_next       = 1'b0;
      overflow_count_next = '0;
    end
    drop = start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= pmd_pkg::PH_IDLE;
      axe_dir        <= 1'b0;
      axe_duty_now   <= '0;
      edge_count     <= '0;
      edge_ref       <= 1'b0;
      overflow_count <= '0;
      settle_count   <= '0;
      chops_left     <= '0;
    end else if (step) begin
      phase          <= phase_next;
      axe_dir        <= axe_dir_next;
      axe_duty_now   <= axe_duty_now_next;
      edge_count     <= edge_count_next;
      edge_ref       <= edge_ref_next;
      overflow_count <= overflow_count_next;
      settle_count   <= settle_count_next;
      chops_left     <= chops_left_next;
    end
  end

  assign res.phase    = phase_next;
  assign res.axe_dir  = axe_dir_next;
  assign res.axe_duty = axe_duty_now_next;
  assign res.axe_drop = drop;

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the motor drive pwm and attack chop sequencer.
// Ticks go in through the s_ stream, a local copy of the drive pwm and chop
// state predicts the pin levels of every tick and the m_ stream is checked
// against them. Register settings change between runs of ticks, both sides
// stall at random, and one run goes without any stalls.
// ----------------------------------------------------------------------------

module tb;

  localparam int LEVELS         = pmd_pkg::SPEED_LEVELS_DEF;
  localparam int PWM_TOP        = (1 << pmd_pkg::PWM_BITS_DEF) - 1;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RUN_TICKS      = 250;
  localparam int RUNS           = 8;

  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_ONCE   = 2'd1;
  localparam logic [1:0] ACT_REPEAT = 2'd2;
  localparam logic [1:0] ACT_RSVD   = 2'd3;

  localparam logic [2:0] REG_DOWN_EDGES    = 3'd0;
  localparam logic [2:0] REG_UP_EDGES      = 3'd1;
  localparam logic [2:0] REG_TIMEOUT_LIMIT = 3'd2;
  localparam logic [2:0] REG_SETTLE_MS     = 3'd3;
  localparam logic [2:0] REG_AXE_DUTY      = 3'd4;
  localparam logic [2:0] REG_REPEAT_CHOPS  = 3'd5;
  localparam logic [2:0] REG_MIN_DUTY      = 3'd6;
  localparam logic [2:0] REG_DUTY_SPAN     = 3'd7;

  // first field in the lowest bits, so the last member here
  typedef struct packed {
    logic       right_reverse;
    logic       left_reverse;
    logic [3:0] right_level;
    logic [3:0] left_level;
    logic       encoder_level;
    logic       ms_tick;
    logic       timeout_tick;
    logic       pwm_tick;
    logic [1:0] action;
  } tick_t;

  typedef struct packed {
    logic [5:0] pad;
    logic [2:0] phase;
    logic       busy;
    logic       axe_dir;
    logic       right_dir;
    logic       left_dir;
    logic       axe_en;
    logic       right_en;
    logic       left_en;
  } pins_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [15:0] s_tdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] m_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [9:0]  cfg_wdata = '0;

  pwm_motor_drive_and_chop_sequencer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // local copy of registers and state
  pmd_pkg::seq_cfg_t chop_cfg = '{down_edges: 8'd25, up_edges: 8'd35,
                                  timeout_limit: 4'd5, settle_ms: 10'd100,
                                  axe_duty: 8'd128, repeat_chops: 4'd5};
  logic [7:0]  drive_min = 8'd60;
  logic [7:0]  drive_span = 8'd90;
  logic [7:0]  pwm_cnt = '0;
  logic [2:0]  en_bits = '0;
  logic [1:0]  last_rev = '0;
  logic        axe_dir_q = 1'b0;
  pmd_pkg::phase_t seq_ph = pmd_pkg::PH_IDLE;
  logic [7:0]  edge_cnt = '0;
  logic        edge_ref = 1'b0;
  logic [3:0]  ovf_cnt = '0;
  logic [9:0]  settle_cnt = '0;
  logic [3:0]  chops_left = '0;
  logic [7:0]  axe_duty_now = '0;

  tick_t       tick_queue[$];
  pins_t       pins_due[$];
  tick_t       held;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  logic        steady = 1'b0;
  logic        enc_now = 1'b0;
  logic        lrev_now = 1'b0;
  logic        rrev_now = 1'b0;

  function automatic int level_duty(logic [3:0] level);
    int lv;
    int d;
    lv = (level > LEVELS) ? LEVELS : int'(level);
    if (lv == 0) return 0;
    d = int'(drive_min) + (lv * int'(drive_span)) / LEVELS;
    return (d > PWM_TOP) ? PWM_TOP : d;
  endfunction

  task automatic begin_stroke(pmd_pkg::phase_t ph);
    seq_ph       = ph;
    axe_dir_q    = (ph == pmd_pkg::PH_DOWN);
    axe_duty_now = chop_cfg.axe_duty;
    edge_cnt     = '0;
    edge_ref     = 1'b0;
    ovf_cnt      = '0;
    en_bits[2]   = 1'b0;
  endtask

  task automatic end_stroke();
    axe_duty_now = '0;
    settle_cnt   = '0;
    seq_ph       = (seq_ph == pmd_pkg::PH_DOWN) ? pmd_pkg::PH_SDOWN : pmd_pkg::PH_SUP;
  endtask

  // one tick of the drive and chop state, queues the pin levels it gives
  task automatic advance_drive_model(tick_t t);
    int    ldut;
    int    rdut;
    int    target;
    pins_t want;
    ldut = level_duty(t.left_level);
    rdut = level_duty(t.right_level);

    if (seq_ph == pmd_pkg::PH_DOWN || seq_ph == pmd_pkg::PH_UP) begin
      target = (seq_ph == pmd_pkg::PH_DOWN) ? chop_cfg.down_edges : chop_cfg.up_edges;
      if (t.timeout_tick && ovf_cnt >= chop_cfg.timeout_limit) begin
        ovf_cnt = '0;
        end_stroke();
      end else begin
        if (t.timeout_tick) ovf_cnt = ovf_cnt + 4'd1;
        if (t.encoder_level != edge_ref) begin
          edge_ref = t.encoder_level;
          if (edge_cnt != 8'hFF) edge_cnt = edge_cnt + 8'd1;
        end
        if (edge_cnt >= target) end_stroke();
      end
    end else if (seq_ph == pmd_pkg::PH_SDOWN || seq_ph == pmd_pkg::PH_SUP) begin
      if (t.ms_tick && settle_cnt != 10'h3FF) settle_cnt = settle_cnt + 10'd1;
      if (settle_cnt >= chop_cfg.settle_ms) begin
        if (seq_ph == pmd_pkg::PH_SDOWN) begin
          begin_stroke(pmd_pkg::PH_UP);
        end else begin
          chops_left = (chops_left != 0) ? chops_left - 4'd1 : 4'd0;
          if (chops_left != 0) begin_stroke(pmd_pkg::PH_DOWN);
          else seq_ph = pmd_pkg::PH_IDLE;
        end
      end
    end else begin
      seq_ph = pmd_pkg::PH_IDLE;
      if (t.action == ACT_ONCE || t.action == ACT_REPEAT) begin
        chops_left = (t.action == ACT_ONCE) ? 4'd1 : chop_cfg.repeat_chops;
        if (chops_left == 0) chops_left = 4'd1;
        begin_stroke(pmd_pkg::PH_DOWN);
      end
    end

    // a direction change drops the channel until the next pwm tick
    if (t.left_reverse != last_rev[0]) en_bits[0] = 1'b0;
    if (t.right_reverse != last_rev[1]) en_bits[1] = 1'b0;
    last_rev = {t.right_reverse, t.left_reverse};

    if (t.pwm_tick) begin
      en_bits[0] = int'(pwm_cnt) < ldut;
      en_bits[1] = int'(pwm_cnt) < rdut;
      en_bits[2] = pwm_cnt < axe_duty_now;
      pwm_cnt = (int'(pwm_cnt) >= PWM_TOP) ? 8'd0 : pwm_cnt + 8'd1;
    end

    want           = '0;
    want.left_en   = en_bits[0];
    want.right_en  = en_bits[1];
    want.axe_en    = en_bits[2];
    want.left_dir  = ~t.left_reverse;
    want.right_dir = t.right_reverse;
    want.axe_dir   = axe_dir_q;
    want.busy      = (seq_ph != pmd_pkg::PH_IDLE);
    want.phase     = seq_ph;
    pins_due.push_back(want);
  endtask

  task automatic note_mismatch(string what);
    mismatches++;
    $display("%0t: mismatch, %s", $time, what);
  endtask

  task automatic check_pins(pins_t got);
    pins_t want;
    if (pins_due.size() == 0) begin
      note_mismatch($sformatf("unexpected transfer %h", got));
    end else begin
      want = pins_due.pop_front();
      if (got.left_en !== want.left_en)
        note_mismatch($sformatf("left_enable %b, want %b", got.left_en, want.left_en));
      if (got.right_en !== want.right_en)
        note_mismatch($sformatf("right_enable %b, want %b", got.right_en, want.right_en));
      if (got.axe_en !== want.axe_en)
        note_mismatch($sformatf("axe_enable %b, want %b", got.axe_en, want.axe_en));
      if (got.left_dir !== want.left_dir)
        note_mismatch($sformatf("left_dir_pin %b, want %b", got.left_dir, want.left_dir));
      if (got.right_dir !== want.right_dir)
        note_mismatch($sformatf("right_dir_pin %b, want %b", got.right_dir, want.right_dir));
      if (got.axe_dir !== want.axe_dir)
        note_mismatch($sformatf("axe_dir_pin %b, want %b", got.axe_dir, want.axe_dir));
      if (got.busy !== want.busy)
        note_mismatch($sformatf("busy_res %b, want %b", got.busy, want.busy));
      if (got.phase !== want.phase)
        note_mismatch($sformatf("phase %0d, want %0d", got.phase, want.phase));
    end
  endtask

  // driver: the held item stays on the bus until its transfer
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) advance_drive_model(held);
      if (!s_tvalid || s_tready) begin
        if (tick_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 21)) begin
          held = tick_queue.pop_front();
          s_tdata  <= held;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_pins(pins_t'(m_tdata));
      m_tready <= steady || ($urandom_range(0, 99) >= 21);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic tick_t mk(logic [1:0] act, logic pwm, logic tmo, logic ms, logic enc,
                               logic [3:0] ll, logic [3:0] rl, logic lr, logic rr);
    tick_t t;
    t.action        = act;
    t.pwm_tick      = pwm;
    t.timeout_tick  = tmo;
    t.ms_tick       = ms;
    t.encoder_level = enc;
    t.left_level    = ll;
    t.right_level   = rl;
    t.left_reverse  = lr;
    t.right_reverse = rr;
    return t;
  endfunction

  // encoder and directions wander, so strokes see real edge runs
  function automatic tick_t random_tick();
    int          r;
    logic [1:0]  act;
    r = $urandom_range(0, 99);
    act = (r < 6) ? ACT_ONCE : (r < 12) ? ACT_REPEAT : (r < 14) ? ACT_RSVD : ACT_NONE;
    if ($urandom_range(0, 1)) enc_now = ~enc_now;
    if ($urandom_range(0, 9) == 0) lrev_now = ~lrev_now;
    if ($urandom_range(0, 9) == 0) rrev_now = ~rrev_now;
    return mk(act, $urandom_range(0, 99) < 75, $urandom_range(0, 99) < 15,
              $urandom_range(0, 99) < 60, enc_now, 4'($urandom_range(0, 15)),
              4'($urandom_range(0, 15)), lrev_now, rrev_now);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [9:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_DOWN_EDGES:    chop_cfg.down_edges    = val[7:0];
      REG_UP_EDGES:      chop_cfg.up_edges      = val[7:0];
      REG_TIMEOUT_LIMIT: chop_cfg.timeout_limit = val[3:0];
      REG_SETTLE_MS:     chop_cfg.settle_ms     = val;
      REG_AXE_DUTY:      chop_cfg.axe_duty      = val[7:0];
      REG_REPEAT_CHOPS:  chop_cfg.repeat_chops  = val[3:0];
      REG_MIN_DUTY:      drive_min              = val[7:0];
      REG_DUTY_SPAN:     drive_span             = val[7:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(int de, int ue, int tl, int sm, int ad, int rc, int md, int ds);
    write_reg(REG_DOWN_EDGES, 10'(de));
    write_reg(REG_UP_EDGES, 10'(ue));
    write_reg(REG_TIMEOUT_LIMIT, 10'(tl));
    write_reg(REG_SETTLE_MS, 10'(sm));
    write_reg(REG_AXE_DUTY, 10'(ad));
    write_reg(REG_REPEAT_CHOPS, 10'(rc));
    write_reg(REG_MIN_DUTY, 10'(md));
    write_reg(REG_DUTY_SPAN, 10'(ds));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every tick has gone through and its pins came back
  task automatic drain();
    while (tick_queue.size() != 0 || s_tvalid || pins_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    while (rst) @(posedge clk);

    // reset settings: level extremes, direction drops, ignored requests,
    // then a down stroke ended by timeout
    tick_queue.push_back(mk(ACT_NONE, 0, 0, 0, 0, 0, 0, 0, 0));
    tick_queue.push_back(mk(ACT_NONE, 1, 0, 0, 0, 8, 8, 0, 0));
    tick_queue.push_back(mk(ACT_NONE, 1, 0, 0, 1, 15, 15, 1, 0));
    tick_queue.push_back(mk(ACT_NONE, 0, 0, 0, 1, 15, 15, 1, 1));
    tick_queue.push_back(mk(ACT_NONE, 1, 0, 1, 0, 1, 0, 0, 1));
    tick_queue.push_back(mk(ACT_RSVD, 1, 0, 0, 0, 4, 12, 0, 0));
    tick_queue.push_back(mk(ACT_ONCE, 1, 0, 0, 0, 8, 8, 0, 0));
    tick_queue.push_back(mk(ACT_REPEAT, 1, 0, 0, 1, 8, 8, 0, 0));
    for (int i = 0; i < 6; i++)
      tick_queue.push_back(mk(ACT_NONE, 1, 1, 1, i[0], 7, 2, 0, 0));
    drain();

    // zero targets and settle, saturating duties, repeat count of zero
    program_regs(0, 0, 0, 0, 255, 0, 255, 255);
    tick_queue.push_back(mk(ACT_NONE, 1, 0, 0, 0, 8, 3, 0, 0));
    tick_queue.push_back(mk(ACT_NONE, 1, 0, 1, 0, 8, 3, 0, 0));
    tick_queue.push_back(mk(ACT_NONE, 1, 0, 0, 0, 8, 3, 0, 0));
    tick_queue.push_back(mk(ACT_REPEAT, 1, 0, 0, 0, 15, 9, 1, 1));
    for (int i = 0; i < 4; i++)
      tick_queue.push_back(mk(ACT_NONE, 1, 0, 0, 1, 8, 8, 1, 1));
    tick_queue.push_back(mk(ACT_ONCE, 1, 0, 0, 0, 0, 0, 1, 1));
    tick_queue.push_back(mk(ACT_NONE, 1, 1, 0, 0, 0, 0, 1, 1));
    tick_queue.push_back(mk(ACT_NONE, 1, 0, 0, 0, 0, 0, 1, 1));
    drain();

    for (int run = 0; run < RUNS; run++) begin
      case (run)
        0: program_regs(255, 255, 15, 1023, 255, 15, 255, 255);
        1: program_regs(0, 0, 0, 0, 0, 1, 0, 0);
        2: program_regs(25, 35, 5, 100, 128, 5, 60, 90);
        default: program_regs($urandom_range(0, 12), $urandom_range(0, 12),
                              $urandom_range(0, 15), $urandom_range(0, 20),
                              $urandom_range(0, 255), $urandom_range(0, 15),
                              $urandom_range(0, 255), $urandom_range(0, 255));
      endcase
      steady = (run == 4);
      for (int i = 0; i < RUN_TICKS; i++) tick_queue.push_back(random_tick());
      drain();
    end

    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

### pwm_motor_drive_and_chop_sequencer.f
hw/rtl/pmd_pkg.sv
hw/rtl/pmd_level_duty.sv
hw/rtl/pmd_chop_seq.sv
hw/rtl/pwm_motor_drive_and_chop_sequencer.sv
tb/sv/tb.sv
